FILE: hdl/light_phase_schedule_sequencer_assert.svh
// Assertion macros shared by the light phase schedule sequencer modules.
`ifndef LIGHT_PHASE_SCHEDULE_SEQUENCER_ASSERT_SVH
`define LIGHT_PHASE_SCHEDULE_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every rising edge, skipped while reset is high.
`define LPSS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define LPSS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPSS_ASSERT(label, clk, rst, prop, msg)
`define LPSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

FILE: hdl/lpss_pkg.sv
// Types, constants and codes of the light phase schedule sequencer.
package lpss_pkg;

  localparam int MAX_ENTRIES_DEF = 8;

  localparam int CMD_W     = 2;
  localparam int ELAPSED_W = 32;
  localparam int WIDX_W    = 3;
  localparam int SEC_W     = 22;
  localparam int REP_W     = 8;
  localparam int LEVEL_W   = 7;
  localparam int POS_W     = 4;
  localparam int TICK_W    = 10;
  localparam int MS_W      = 32;
  localparam int DUR_W     = SEC_W + 1;
  localparam int SPAN_W    = DUR_W + REP_W;
  localparam int QBIT_W    = 3;
  localparam int PROD_W    = DUR_W + 10;

  localparam int MS_PER_SECOND = 1000;
  localparam logic [LEVEL_W-1:0] LEVEL_ON  = LEVEL_W'(100);
  localparam logic [LEVEL_W-1:0] LEVEL_OFF = '0;
  localparam logic [TICK_W-1:0]  TICK_MS_RESET = TICK_W'(100);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_RESYNC  = 2'd1,
    CMD_WRITE   = 2'd2,
    CMD_RESTART = 2'd3
  } command_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCHEDULE_COUNT = 2'd0,
    REG_TICK_MS        = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [SEC_W-1:0] on_s;
    logic [SEC_W-1:0] off_s;
    logic [REP_W-1:0] reps;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_RESTART,
    S_TICK_RD,
    S_TICK_MUL,
    S_TICK_EXEC,
    S_RS_RD,
    S_RS_SPAN,
    S_RS_MUL,
    S_RS_CMP,
    S_RS_DIV,
    S_RS_FIN1,
    S_RS_FIN2,
    S_RS_FIN3,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic in_load;
    logic mem_write;
    logic restart;
    logic rd_tick;
    logic tick_mul;
    logic tick_exec;
    logic rd_walk;
    logic rs_span;
    logic rs_mul;
    logic rs_cmp;
    logic div_step;
    logic rs_fin1;
    logic rs_fin2;
    logic rs_commit;
    logic rs_finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_end;
    logic dur_zero;
    logic in_range;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/lpss_if.sv
// Channel interfaces: input item, result word and configuration write.
interface lpss_item_if import lpss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [ELAPSED_W-1:0] elapsed_seconds;
  logic [WIDX_W-1:0]    entry_index;
  logic [SEC_W-1:0]     on_seconds;
  logic [SEC_W-1:0]     off_seconds;
  logic [REP_W-1:0]     repeat_count;

  modport source (output valid, command, elapsed_seconds, entry_index, on_seconds,
                  off_seconds, repeat_count, input ready);
  modport sink (input valid, command, elapsed_seconds, entry_index, on_seconds,
                off_seconds, repeat_count, output ready);
endinterface

interface lpss_result_if import lpss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] light_level;
  logic               level_changed;
  logic               phase_is_on;
  logic               all_done;
  logic [POS_W-1:0]   entry_position;
  logic [REP_W-1:0]   repetition_position;

  modport source (output valid, light_level, level_changed, phase_is_on, all_done,
                  entry_position, repetition_position, input ready);
  modport sink (input valid, light_level, level_changed, phase_is_on, all_done,
                entry_position, repetition_position, output ready);
endinterface

interface lpss_cfg_if import lpss_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/lpss_ctrl.sv
// Controller state machine: sequences tick, resync, write and restart items.
`include "light_phase_schedule_sequencer_assert.svh"

module lpss_ctrl import lpss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic [CMD_W-1:0] item_command,
  output logic             in_ready,
  input  status_t          status,
  output cmd_t             cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (item_valid) begin
          cmd.in_load = 1'b1;
          case (command_t'(item_command))
            CMD_TICK:    state_next = S_TICK_RD;
            CMD_RESYNC:  state_next = S_RS_RD;
            CMD_WRITE:   state_next = S_WRITE;
            CMD_RESTART: state_next = S_RESTART;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.mem_write = 1'b1;
        state_next    = S_EMIT;
      end
      S_RESTART: begin
        cmd.restart = 1'b1;
        state_next  = S_EMIT;
      end
      S_TICK_RD: begin
        cmd.rd_tick = 1'b1;
        state_next  = S_TICK_MUL;
      end
      S_TICK_MUL: begin
        cmd.tick_mul = 1'b1;
        state_next   = S_TICK_EXEC;
      end
      S_TICK_EXEC: begin
        cmd.tick_exec = 1'b1;
        state_next    = S_EMIT;
      end
      S_RS_RD: begin
        if (status.walk_end) begin
          cmd.rs_finish = 1'b1;
          state_next    = S_EMIT;
        end else begin
          cmd.rd_walk = 1'b1;
          state_next  = S_RS_SPAN;
        end
      end
      S_RS_SPAN: begin
        cmd.rs_span = 1'b1;
        state_next  = S_RS_MUL;
      end
      S_RS_MUL: begin
        cmd.rs_mul = 1'b1;
        state_next = status.dur_zero ? S_RS_RD : S_RS_CMP;
      end
      S_RS_CMP: begin
        cmd.rs_cmp = 1'b1;
        state_next = status.in_range ? S_RS_DIV : S_RS_RD;
      end
      S_RS_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_RS_FIN1;
        end
      end
      S_RS_FIN1: begin
        cmd.rs_fin1 = 1'b1;
        state_next  = S_RS_FIN2;
      end
      S_RS_FIN2: begin
        cmd.rs_fin2 = 1'b1;
        state_next  = S_RS_FIN3;
      end
      S_RS_FIN3: begin
        cmd.rs_commit = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        // hold here until the result register is free
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `LPSS_ASSERT(a_tick_starts_read, clk, rst, (item_valid && in_ready && item_command == CMD_TICK) |=> state == S_TICK_RD, "tick item did not start a table read")
  `LPSS_ASSERT(a_emit_returns_idle, clk, rst, cmd.out_load |=> (state == S_IDLE && !cmd.out_load), "result load not followed by idle")
  `LPSS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> state == S_IDLE, "controller not idle after reset")

endmodule

FILE: hdl/lpss_dp.sv
// Datapath: configuration, entry table, schedule state, resync walk and result word.
`include "light_phase_schedule_sequencer_assert.svh"

module lpss_dp import lpss_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output status_t                status,
  // item payload
  input  logic [ELAPSED_W-1:0]   in_elapsed_seconds,
  input  logic [WIDX_W-1:0]      in_entry_index,
  input  logic [SEC_W-1:0]       in_on_seconds,
  input  logic [SEC_W-1:0]       in_off_seconds,
  input  logic [REP_W-1:0]       in_repeat_count,
  // configuration writes
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // result word
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [LEVEL_W-1:0]     out_light_level,
  output logic                   out_level_changed,
  output logic                   out_phase_is_on,
  output logic                   out_all_done,
  output logic [POS_W-1:0]       out_entry_position,
  output logic [REP_W-1:0]       out_repetition_position
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // configuration
  logic [POS_W-1:0]  schedule_count;
  logic [TICK_W-1:0] tick_ms;
  logic [POS_W-1:0]  count;

  // latched item payload
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [WIDX_W-1:0]    widx_r;
  entry_t               wentry_r;

  // entry table
  entry_t mem [MAX_ENTRIES];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_ok;

  // schedule state
  logic [POS_W-1:0]   pos;
  logic [REP_W-1:0]   rep;
  logic               lamp_lit;
  logic [MS_W-1:0]    phase_len;
  logic [MS_W-1:0]    phase_elapsed;
  logic               finished;
  logic [LEVEL_W-1:0] level;
  logic               changed;

  // resync walk and shared multiplier
  logic [POS_W-1:0]  walk_idx;
  logic [MS_W-1:0]   acc;
  logic [DUR_W-1:0]  dur_r;
  logic [SPAN_W-1:0] span_r;
  logic [SPAN_W-1:0] rem;
  logic [REP_W-1:0]  quo;
  logic [QBIT_W-1:0] div_k;
  logic              rs_on;
  logic [REP_W-1:0]  rs_rep;
  logic [DUR_W-1:0]  mul_op_r;
  logic [MS_W-1:0]   prod;

  logic [DUR_W-1:0]  mul_in;
  logic [PROD_W-1:0] prod_full;
  logic [MS_W:0]     tick_sum;
  logic [MS_W-1:0]   elapsed_next;
  logic [MS_W:0]     reach;
  logic [SPAN_W-1:0] shifted;
  logic [SPAN_W-1:0] on_ext;
  logic              rs_on_next;

  assign count = (int'(schedule_count) > MAX_ENTRIES) ? POS_W'(MAX_ENTRIES) : schedule_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      schedule_count <= '0;
      tick_ms        <= TICK_MS_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCHEDULE_COUNT: schedule_count <= cfg_data[POS_W-1:0];
        REG_TICK_MS:        tick_ms        <= cfg_data[TICK_W-1:0];
        default:            ;
      endcase
    end
  end

  // entry table: one write port, one registered read port
  assign wr_ok   = int'(widx_r) < MAX_ENTRIES;
  assign rd_addr = cmd.rd_tick ? AW'(pos) : AW'(walk_idx);

  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_ok) begin
      mem[AW'(widx_r)] <= wentry_r;
    end
    if (cmd.rd_tick || cmd.rd_walk) begin
      rd_data <= mem[rd_addr];
    end
  end

  // shared seconds-to-milliseconds multiplier
  assign mul_in    = cmd.tick_mul ? (lamp_lit ? DUR_W'(rd_data.off_s) : DUR_W'(rd_data.on_s))
                                  : mul_op_r;
  assign prod_full = PROD_W'(mul_in) * PROD_W'(MS_PER_SECOND);

  assign tick_sum     = {1'b0, phase_elapsed} + (MS_W + 1)'(tick_ms);
  assign elapsed_next = tick_sum[MS_W] ? '1 : tick_sum[MS_W-1:0];

  assign reach      = {1'b0, acc} + (MS_W + 1)'(span_r);
  assign shifted    = SPAN_W'(dur_r) << div_k;
  assign on_ext     = SPAN_W'(rd_data.on_s);
  assign rs_on_next = rem < on_ext;

  assign status.walk_end = walk_idx >= count;
  assign status.dur_zero = dur_r == '0;
  assign status.in_range = {1'b0, elapsed_r} < reach;
  assign status.div_last = div_k == '0;
  assign status.out_free = !out_valid || out_ready;

  // payload latches and resync working registers
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      elapsed_r      <= in_elapsed_seconds;
      widx_r         <= in_entry_index;
      wentry_r.on_s  <= in_on_seconds;
      wentry_r.off_s <= in_off_seconds;
      wentry_r.reps  <= in_repeat_count;
      walk_idx       <= '0;
      acc            <= '0;
    end
    if (cmd.tick_mul || cmd.rs_fin2) begin
      prod <= prod_full[MS_W-1:0];
    end
    if (cmd.rs_span) begin
      dur_r <= DUR_W'(rd_data.on_s) + DUR_W'(rd_data.off_s);
    end
    if (cmd.rs_mul) begin
      if (dur_r == '0) begin
        walk_idx <= walk_idx + POS_W'(1);
      end else begin
        span_r <= SPAN_W'(dur_r) * SPAN_W'(rd_data.reps);
      end
    end
    if (cmd.rs_cmp) begin
      if ({1'b0, elapsed_r} < reach) begin
        rem   <= SPAN_W'(elapsed_r - acc);
        quo   <= '0;
        div_k <= QBIT_W'(REP_W - 1);
      end else begin
        acc      <= reach[MS_W-1:0];
        walk_idx <= walk_idx + POS_W'(1);
      end
    end
    // one quotient bit per cycle: repetition number and offset into it
    if (cmd.div_step) begin
      if (rem >= shifted) begin
        rem        <= rem - shifted;
        quo[div_k] <= 1'b1;
      end
      div_k <= div_k - QBIT_W'(1);
    end
    if (cmd.rs_fin1) begin
      rs_on    <= rs_on_next;
      mul_op_r <= rs_on_next ? DUR_W'(on_ext - rem) : DUR_W'(SPAN_W'(dur_r) - rem);
      rs_rep   <= rs_on_next ? quo : quo + REP_W'(1);
    end
  end

  // schedule state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      rep           <= '0;
      lamp_lit      <= 1'b0;
      phase_len     <= '0;
      phase_elapsed <= '0;
      finished      <= 1'b0;
      level         <= LEVEL_OFF;
      changed       <= 1'b0;
    end else begin
      if (cmd.in_load) begin
        changed <= 1'b0;
      end
      if (cmd.restart) begin
        pos           <= '0;
        rep           <= '0;
        lamp_lit      <= 1'b0;
        phase_len     <= '0;
        phase_elapsed <= '0;
        finished      <= 1'b0;
      end
      if (cmd.tick_exec) begin
        if (finished) begin
          level   <= LEVEL_OFF;
          changed <= level != LEVEL_OFF;
        end else begin
          if (pos >= count) begin
            phase_elapsed <= elapsed_next;
            finished      <= 1'b1;
            level         <= LEVEL_OFF;
            changed       <= level != LEVEL_OFF;
          end else if (rep < rd_data.reps) begin
            if (phase_len == '0) begin
              phase_len     <= prod;
              phase_elapsed <= '0;
              if (!lamp_lit) begin
                lamp_lit <= 1'b1;
                level    <= LEVEL_ON;
                changed  <= level != LEVEL_ON;
              end else begin
                lamp_lit <= 1'b0;
                level    <= LEVEL_OFF;
                changed  <= level != LEVEL_OFF;
                rep      <= rep + REP_W'(1);
              end
            end else begin
              phase_elapsed <= elapsed_next;
              if (elapsed_next >= phase_len) begin
                phase_len <= '0;
              end
            end
          end else begin
            phase_elapsed <= elapsed_next;
            pos           <= pos + POS_W'(1);
            rep           <= '0;
            lamp_lit      <= 1'b0;
            phase_len     <= '0;
          end
        end
      end
      if (cmd.rs_commit) begin
        pos           <= walk_idx;
        rep           <= rs_rep;
        lamp_lit      <= rs_on;
        phase_len     <= prod;
        phase_elapsed <= '0;
        finished      <= 1'b0;
      end
      if (cmd.rs_finish) begin
        pos      <= count;
        finished <= 1'b1;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_light_level         <= level;
      out_level_changed       <= changed;
      out_phase_is_on         <= lamp_lit;
      out_all_done            <= finished;
      out_entry_position      <= pos;
      out_repetition_position <= rep;
    end
  end

  `LPSS_ASSERT(a_level_two_values, clk, rst, (level == LEVEL_OFF) || (level == LEVEL_ON), "light level neither off nor on")
  `LPSS_ASSERT(a_div_remainder, clk, rst, cmd.rs_fin1 |-> (rem < SPAN_W'(dur_r)), "resync remainder not below entry period")
  `LPSS_ASSERT(a_finished_dark, clk, rst, (cmd.tick_exec && finished) |=> (level == LEVEL_OFF && finished), "finished schedule left the light on")

endmodule

FILE: hdl/light_phase_schedule_sequencer.sv
// Top level of the light phase schedule sequencer: controller, datapath and channel wiring.
// Write and restart items go straight to the result word; a tick reads the table entry,
// converts the phase length and steps the schedule; a resync walks the table entry by
// entry, divides out the repetition where the time lies, or finishes past the last entry.
// One item at a time: the next item is taken the cycle after the result word is loaded,
// and a waiting result word holds the block; each table read is registered.
// Synchronous active-high reset clears the schedule position, light state and config
// (schedule_count 0, tick_ms 100); the entry table is undefined until written.
module light_phase_schedule_sequencer import lpss_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lpss_item_if.sink     item,
  lpss_result_if.source result,
  lpss_cfg_if.sink      cfg
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // configuration writes are taken on any cycle outside reset
  assign cfg.ready  = !rst;
  assign item.ready = in_ready && !rst;

  // controller: decode the command word, step through the item's work
  lpss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_command (item.command),
    .in_ready     (in_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // datapath: table, schedule state, resync walk and the result register
  lpss_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk                     (clk),
    .rst                     (rst),
    .cmd                     (cmd),
    .status                  (status),
    .in_elapsed_seconds      (item.elapsed_seconds),
    .in_entry_index          (item.entry_index),
    .in_on_seconds           (item.on_seconds),
    .in_off_seconds          (item.off_seconds),
    .in_repeat_count         (item.repeat_count),
    .cfg_write               (cfg.valid),
    .cfg_index               (cfg.index),
    .cfg_data                (cfg.data),
    .out_ready               (result.ready),
    .out_valid               (result.valid),
    .out_light_level         (result.light_level),
    .out_level_changed       (result.level_changed),
    .out_phase_is_on         (result.phase_is_on),
    .out_all_done            (result.all_done),
    .out_entry_position      (result.entry_position),
    .out_repetition_position (result.repetition_position)
  );

endmodule
